// ===== hw/rtl/gn3_pkg.sv =====
package gn3_pkg;

   localparam int TableSizeDefault = 256;
   localparam int CoordFracDefault = 16;

   localparam int CmdW   = 2;
   localparam int CoordW = 32;
   localparam int GradW  = 16;
   localparam int PermW  = 8;
   localparam int IdxInW = 8;
   localparam int OutW   = 20;

   localparam logic [CmdW-1:0] CMD_EVAL   = 2'd0;
   localparam logic [CmdW-1:0] CMD_PERM   = 2'd1;
   localparam logic [CmdW-1:0] CMD_GRAD   = 2'd2;
   localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

   // request word packed in tdata, lowest field first
   typedef struct packed {
      logic signed [GradW-1:0]  grad_z;
      logic signed [GradW-1:0]  grad_y;
      logic signed [GradW-1:0]  grad_x;
      logic [PermW-1:0]         perm_entry;
      logic [IdxInW-1:0]        entry_index;
      logic signed [CoordW-1:0] coord_z;
      logic signed [CoordW-1:0] coord_y;
      logic signed [CoordW-1:0] coord_x;
      logic [CmdW-1:0]          command;
   } req_type;

   localparam int ReqW = $bits(req_type);
   localparam int ReqBytesW = ((ReqW + 7) / 8) * 8;

endpackage

// ===== hw/rtl/gn3_front.sv =====
module gn3_front
   import gn3_pkg::*;
#(
   parameter int TABLE_SIZE      = TableSizeDefault,
   parameter int COORD_FRAC_BITS = CoordFracDefault,
   parameter int DEPTH           = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  req_type             in_req,
   output logic                q_valid,
   input  logic                q_ready,
   output req_type             q_req
);
   // small fifo between intake and the evaluation pipeline
   localparam int AW = $clog2(DEPTH);
   req_type           mem [DEPTH];
   logic [AW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign push     = in_valid && in_ready && (in_req.command != CMD_UNUSED);
   assign pop      = q_valid && q_ready;
   assign q_req    = mem[rp_ff];

   always_comb begin
      wp_in  = push ? ((wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? ((rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= in_req;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== hw/rtl/gn3_back.sv =====
module gn3_back
   import gn3_pkg::*;
#(
   parameter int TABLE_SIZE      = TableSizeDefault,
   parameter int COORD_FRAC_BITS = CoordFracDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  req_type                in_req,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [OutW-1:0] out_noise
);
   localparam int F   = COORD_FRAC_BITS;
   localparam int TW  = $clog2(TABLE_SIZE);
   localparam int NS  = 9;
   localparam int OFW = F + 2;          // signed offset
   localparam int DW  = GradW + OFW + 2;// dot product width
   localparam int VW  = DW - F + 3;     // q16 corner value
   localparam int SW  = F + 2;          // smooth weight, 0..2^F

   // stage valid and global stall; pipeline advances only if tail frees
   logic [NS-1:0] v_ff;
   logic          adv;
   assign adv       = !v_ff[NS-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = v_ff[NS-1];

   logic           ld_perm, ld_grad, eval_in;
   logic [TW-1:0]  widx;
   assign ld_perm = in_valid && adv && in_req.command == CMD_PERM;
   assign ld_grad = in_valid && adv && in_req.command == CMD_GRAD;
   assign eval_in = in_valid && adv && in_req.command == CMD_EVAL;
   assign widx    = TW'(in_req.entry_index);

   // perm table: two reads per axis (cell and cell + 1), one copy per axis
   logic [PermW-1:0]     perm_x [TABLE_SIZE];
   logic [PermW-1:0]     perm_y [TABLE_SIZE];
   logic [PermW-1:0]     perm_z [TABLE_SIZE];
   logic [3*GradW-1:0]   grad_m [8][TABLE_SIZE];

   // gradient writes travel down to the read stage so loads and evals keep their order
   logic               gw1_ff, gw2_ff, gw3_ff;
   logic [TW-1:0]      gi1_ff, gi2_ff, gi3_ff;
   logic [3*GradW-1:0] gd1_ff, gd2_ff, gd3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         gw1_ff <= 1'b0; gw2_ff <= 1'b0; gw3_ff <= 1'b0;
      end else if (adv) begin
         gw1_ff <= ld_grad; gw2_ff <= gw1_ff; gw3_ff <= gw2_ff;
      end
      if (adv) begin
         gi1_ff <= widx; gi2_ff <= gi1_ff; gi3_ff <= gi2_ff;
         gd1_ff <= {in_req.grad_z, in_req.grad_y, in_req.grad_x};
         gd2_ff <= gd1_ff; gd3_ff <= gd2_ff;
      end
   end

   // stage 1: split coordinates
   logic [TW-1:0]  c0_ff [3];
   logic [F-1:0]   f1_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         c0_ff[0] <= in_req.coord_x[F +: TW];
         c0_ff[1] <= in_req.coord_y[F +: TW];
         c0_ff[2] <= in_req.coord_z[F +: TW];
         f1_ff[0] <= in_req.coord_x[F-1:0];
         f1_ff[1] <= in_req.coord_y[F-1:0];
         f1_ff[2] <= in_req.coord_z[F-1:0];
      end
   end

   // stage 2: perm reads (registered memory reads)
   logic [PermW-1:0] p2_ff [3][2];
   logic [F-1:0]     f2_ff [3];
   always_ff @(posedge clock) begin
      if (ld_perm) begin
         perm_x[widx] <= in_req.perm_entry;
         perm_y[widx] <= in_req.perm_entry;
         perm_z[widx] <= in_req.perm_entry;
      end
      if (adv) begin
         p2_ff[0][0] <= perm_x[c0_ff[0]];
         p2_ff[0][1] <= perm_x[c0_ff[0] + 1'b1];
         p2_ff[1][0] <= perm_y[c0_ff[1]];
         p2_ff[1][1] <= perm_y[c0_ff[1] + 1'b1];
         p2_ff[2][0] <= perm_z[c0_ff[2]];
         p2_ff[2][1] <= perm_z[c0_ff[2] + 1'b1];
         f2_ff <= f1_ff;
      end
   end

   // stage 3: hashes; stage 4: gradient reads (one copy per corner)
   logic [TW-1:0]      h3_ff [8];
   logic [F-1:0]       f3_ff [3], f4_ff [3];
   logic [3*GradW-1:0] g4_ff [8];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 8; k++)
            h3_ff[k] <= TW'(p2_ff[0][(k>>2)&1] + p2_ff[1][(k>>1)&1]
                            + p2_ff[2][k&1]);
         f3_ff <= f2_ff;
         f4_ff <= f3_ff;
         for (int k = 0; k < 8; k++) g4_ff[k] <= grad_m[k][h3_ff[k]];
      end
      for (int k = 0; k < 8; k++)
         if (adv && gw3_ff) grad_m[k][gi3_ff] <= gd3_ff;
   end

   // smoothstep in stages 3 and 4
   logic [F-1:0]   sq3_ff [3];
   logic [SW-1:0]  s4_ff [3], s5_ff [3], s6_ff [3], s7_ff [3];
   logic [F+2:0]   tt [3];
   logic [2*F+2:0] sp [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         tt[a] = (F+3)'(3) * (F+3)'(1 << F) - ((F+3)'(f3_ff[a]) << 1);
         sp[a] = (2*F+3)'(sq3_ff[a]) * (2*F+3)'(tt[a]);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            sq3_ff[a] <= F'(((2*F)'(f2_ff[a]) * (2*F)'(f2_ff[a])) >> F);
            s4_ff[a]  <= SW'(sp[a] >> F);
         end
         s5_ff <= s4_ff; s6_ff <= s5_ff; s7_ff <= s6_ff;
      end
   end

   // stage 5: three products per corner; stage 6: sum and round
   logic signed [DW-1:0] pr5_ff [8][3];
   logic signed [VW-1:0] v6_ff [8];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 8; k++)
            for (int a = 0; a < 3; a++)
               pr5_ff[k][a] <= DW'($signed(g4_ff[k][a*GradW +: GradW]))
                  * DW'(((k >> (2-a)) & 1) != 0
                        ? $signed({2'b00, f4_ff[a]}) - $signed(OFW'(1 << F))
                        : $signed({2'b00, f4_ff[a]}));
         for (int k = 0; k < 8; k++)
            v6_ff[k] <= VW'((pr5_ff[k][0] + pr5_ff[k][1] + pr5_ff[k][2]
                           + DW'(1 << (F-3))) >>> (F-2));
      end
   end

   function automatic logic signed [VW-1:0] lerp(input logic signed [VW-1:0] a,
         input logic signed [VW-1:0] b, input logic [SW-1:0] s);
      logic signed [VW+SW+1:0] p;
      p = VW'(0);
      p = (VW+SW+2)'(b - a) * $signed({2'b00, s});
      return VW'(a + VW'(p >>> F));
   endfunction

   logic signed [VW-1:0] l7_ff [4], l8_ff [2];
   logic signed [VW-1:0] r9;
   logic [SW-1:0]        s8_ff;
   logic signed [OutW-1:0] o9_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) l7_ff[k] <= lerp(v6_ff[2*k], v6_ff[2*k+1], s6_ff[2]);
         for (int k = 0; k < 2; k++) l8_ff[k] <= lerp(l7_ff[2*k], l7_ff[2*k+1], s7_ff[1]);
         s8_ff <= s7_ff[0];
         o9_ff <= (r9 > VW'(524287)) ? 20'sd524287 :
                  (r9 < -VW'(524288)) ? -20'sd524288 : OutW'(r9);
      end
   end
   assign r9 = lerp(l8_ff[0], l8_ff[1], s8_ff);
   assign out_noise = o9_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], eval_in};
   end
endmodule

// ===== hw/rtl/gradient_noise_3d.sv =====
// gradient_noise_3d: 3d gradient noise over loadable permutation and gradient tables
// path: an accepted request word passes the intake queue, then nine pipeline stages, to its result word
// throughput: one request word per cycle while the result side does not stall; loads give no result
// the whole pipeline stalls as a block while the result word is not taken
// reset: synchronous, active high; clears fifo and stage valid bits, tables are not cleared
module gradient_noise_3d
   import gn3_pkg::*;
#(
   parameter int TABLE_SIZE      = TableSizeDefault,
   parameter int COORD_FRAC_BITS = CoordFracDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // command, coord_x, coord_y, coord_z, entry_index, perm_entry, grad_x, grad_y, grad_z
   input  logic [ReqBytesW-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // noise_value
   output logic [23:0]          rsp_tdata
);
   req_type in_req, q_req;
   logic    q_valid, q_ready;
   logic signed [OutW-1:0] noise;

   assign in_req = req_type'(req_tdata[ReqW-1:0]);

   // front: intake queue, drops unused command codes
   gn3_front #(.TABLE_SIZE(TABLE_SIZE), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_req,
      .q_valid, .q_ready, .q_req
   );

   // back: table writes and the evaluation pipeline
   gn3_back #(.TABLE_SIZE(TABLE_SIZE), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_noise(noise)
   );

   assign rsp_tdata = {4'b0000, noise};

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // padding bits stay zero
   a_pad: assert property (@(posedge clock) rsp_tdata[23:20] == 4'b0000)
      else $error("padding nonzero");
endmodule
